[sv/normalized_cross_correlation_defines.svh]
// Assertion macros for the normalized cross-correlation block.
// Included by the top level; expects signals named clock and reset in scope.
`ifndef NORMALIZED_CROSS_CORRELATION_DEFINES_SVH
`define NORMALIZED_CROSS_CORRELATION_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define NCC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define NCC_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/ncc_pkg.sv]
// Shared types, constants and width helpers of the normalized cross-correlation block.
// No dependencies.
package ncc_pkg;

   localparam int CFG_W     = 11;
   localparam int PIX_W     = 8;
   localparam int SCORE_W   = 16;
   localparam int LIMB_W    = 32;
   localparam int QUO_W     = 33;
   localparam int ROOT_W    = 17;
   localparam int CSR_IDX_W = 2;

   localparam logic [CFG_W-1:0]   ROW_LENGTH_RST  = 11'd16;
   localparam logic [CFG_W-1:0]   ROW_COUNT_RST   = 11'd16;
   localparam logic [CFG_W-1:0]   SAMPLE_STEP_RST = 11'd1;
   localparam logic [SCORE_W-1:0] SCORE_MAX       = 16'h7FFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_LENGTH  = 2'd0,
      CSR_ROW_COUNT   = 2'd1,
      CSR_SAMPLE_STEP = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL_ISSUE,
      BK_MUL_WAIT,
      BK_DIV,
      BK_SQRT,
      BK_OUT
   } back_state_type;

   // Order of the products formed per window.
   typedef enum logic [2:0] {
      STEP_N_TT,
      STEP_T_T,
      STEP_N_II,
      STEP_I_I,
      STEP_N_TI,
      STEP_T_I,
      STEP_VAR,
      STEP_COV
   } mul_step_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   function automatic int cnt_width(input int max_dim);
      return $clog2(max_dim * max_dim + 1);
   endfunction

   function automatic int sum_width(input int max_dim);
      int cw;
      cw = $clog2(max_dim * max_dim + 1);
      return cw + 2 * (cw + PIX_W) + 3 * (cw + 2 * PIX_W);
   endfunction

endpackage

[sv/ncc_front.sv]
// Front end: configuration registers, window position tracking and pixel sums.
// Pushes one sum record per window into the queue. Depends on ncc_pkg.
module ncc_front #(
   parameter int MAX_DIM = 1024,
   localparam int DIM_W = $clog2(MAX_DIM + 1),
   localparam int CNT_W = ncc_pkg::cnt_width(MAX_DIM),
   localparam int SUM_W = ncc_pkg::sum_width(MAX_DIM)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ncc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ncc_pkg::CFG_W-1:0]      csr_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [ncc_pkg::PIX_W-1:0]      req_template_pixel,
   input  logic [ncc_pkg::PIX_W-1:0]      req_image_pixel,
   input  ncc_pkg::fifo_status_type       fifo_status,
   output logic                           push,
   output logic [SUM_W-1:0]               push_data
);
   import ncc_pkg::*;

   localparam int S1_W = CNT_W + PIX_W;
   localparam int S2_W = CNT_W + 2 * PIX_W;

   logic [CFG_W-1:0] row_length_ff, row_count_ff, sample_step_ff;
   logic [DIM_W-1:0] col_pos_ff, row_pos_ff, col_phase_ff, row_phase_ff;
   logic [DIM_W-1:0] col_pos_in, row_pos_in, col_phase_in, row_phase_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [S1_W-1:0]  st_ff, st_in, si_ff, si_in;
   logic [S2_W-1:0]  stt_ff, stt_in, sii_ff, sii_in, sti_ff, sti_in;
   logic [DIM_W-1:0] lim_len, lim_cnt, lim_stp;
   logic             take_px, row_end, row_last, win_last, accept;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
      if (v == '0) begin
         return DIM_W'(1);
      end else if (int'(v) > MAX_DIM) begin
         return DIM_W'(MAX_DIM);
      end else begin
         return DIM_W'(v);
      end
   endfunction

   assign csr_ready = 1'b1;
   assign lim_len   = clamp_dim(row_length_ff);
   assign lim_cnt   = clamp_dim(row_count_ff);
   assign lim_stp   = clamp_dim(sample_step_ff);
   assign take_px   = (col_phase_ff == '0) && (row_phase_ff == '0);
   assign row_end   = ({1'b0, col_pos_ff} + (DIM_W+1)'(1)) >= {1'b0, lim_len};
   assign row_last  = ({1'b0, row_pos_ff} + (DIM_W+1)'(1)) >= {1'b0, lim_cnt};
   assign win_last  = row_end && row_last;
   // Only the closing pixel of a window needs queue space.
   assign req_ready = !win_last || !fifo_status.full;
   assign accept    = req_valid && req_ready;
   assign push      = accept && win_last;
   assign push_data = {n_in, st_in, stt_in, si_in, sii_in, sti_in};

   always_comb begin
      n_in   = n_ff;
      st_in  = st_ff;
      stt_in = stt_ff;
      si_in  = si_ff;
      sii_in = sii_ff;
      sti_in = sti_ff;
      if (take_px) begin
         n_in   = n_ff + CNT_W'(1);
         st_in  = st_ff + S1_W'(req_template_pixel);
         stt_in = stt_ff + S2_W'(req_template_pixel * req_template_pixel);
         si_in  = si_ff + S1_W'(req_image_pixel);
         sii_in = sii_ff + S2_W'(req_image_pixel * req_image_pixel);
         sti_in = sti_ff + S2_W'(req_template_pixel * req_image_pixel);
      end
   end

   always_comb begin
      col_pos_in   = col_pos_ff;
      row_pos_in   = row_pos_ff;
      col_phase_in = col_phase_ff;
      row_phase_in = row_phase_ff;
      if (row_end) begin
         col_pos_in   = '0;
         col_phase_in = '0;
         if (row_last) begin
            row_pos_in   = '0;
            row_phase_in = '0;
         end else begin
            row_pos_in = row_pos_ff + DIM_W'(1);
            if (({1'b0, row_phase_ff} + (DIM_W+1)'(1)) >= {1'b0, lim_stp}) begin
               row_phase_in = '0;
            end else begin
               row_phase_in = row_phase_ff + DIM_W'(1);
            end
         end
      end else begin
         col_pos_in = col_pos_ff + DIM_W'(1);
         if (({1'b0, col_phase_ff} + (DIM_W+1)'(1)) >= {1'b0, lim_stp}) begin
            col_phase_in = '0;
         end else begin
            col_phase_in = col_phase_ff + DIM_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff  <= ROW_LENGTH_RST;
         row_count_ff   <= ROW_COUNT_RST;
         sample_step_ff <= SAMPLE_STEP_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ROW_LENGTH:  row_length_ff  <= csr_data;
            CSR_ROW_COUNT:   row_count_ff   <= csr_data;
            CSR_SAMPLE_STEP: sample_step_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff   <= '0;
         row_pos_ff   <= '0;
         col_phase_ff <= '0;
         row_phase_ff <= '0;
         n_ff         <= '0;
         st_ff        <= '0;
         stt_ff       <= '0;
         si_ff        <= '0;
         sii_ff       <= '0;
         sti_ff       <= '0;
      end else if (accept) begin
         col_pos_ff   <= col_pos_in;
         row_pos_ff   <= row_pos_in;
         col_phase_ff <= col_phase_in;
         row_phase_ff <= row_phase_in;
         if (win_last) begin
            // start the next window from empty sums
            n_ff   <= '0;
            st_ff  <= '0;
            stt_ff <= '0;
            si_ff  <= '0;
            sii_ff <= '0;
            sti_ff <= '0;
         end else begin
            n_ff   <= n_in;
            st_ff  <= st_in;
            stt_ff <= stt_in;
            si_ff  <= si_in;
            sii_ff <= sii_in;
            sti_ff <= sti_in;
         end
      end
   end

endmodule

[sv/ncc_fifo.sv]
// Two-entry queue that carries window sum records from the front end to the back end.
// Depends on ncc_pkg for the status struct.
module ncc_fifo #(
   parameter int W = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic [W-1:0]             push_data,
   input  logic                     pop,
   output logic [W-1:0]             pop_data,
   output ncc_pkg::fifo_status_type status
);
   import ncc_pkg::*;

   logic [W-1:0] mem_ff [2];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   count_ff;

   assign pop_data     = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         priority if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

[sv/ncc_mul.sv]
// Multi-cycle unsigned multiplier: one 32x32 partial product per cycle, shifted and
// accumulated into a double-width result. Depends on ncc_pkg.
module ncc_mul #(
   parameter int AW = 58,
   localparam int NL = (AW + ncc_pkg::LIMB_W - 1) / ncc_pkg::LIMB_W,
   localparam int PW = NL * ncc_pkg::LIMB_W
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [AW-1:0]   a,
   input  logic [AW-1:0]   b,
   output logic            done,
   output logic [2*PW-1:0] result
);
   import ncc_pkg::*;

   localparam int IW = (NL > 1) ? $clog2(NL) : 1;
   localparam int SW = IW + 1;

   logic [PW-1:0]       a_ff, b_ff;
   logic [IW-1:0]       ia_ff, ib_ff;
   logic                issue_ff, pp_vld_ff, pp_last_ff, done_ff;
   logic [2*LIMB_W-1:0] pp_ff;
   logic [SW-1:0]       sh_ff;
   logic [2*PW-1:0]     acc_ff, pp_shifted;
   logic                last_issue;

   assign last_issue = (ia_ff == IW'(NL - 1)) && (ib_ff == IW'(NL - 1));
   assign pp_shifted = (2*PW)'(pp_ff) << (sh_ff * LIMB_W);
   assign done       = done_ff;
   assign result     = acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff  <= 1'b0;
         pp_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         pp_vld_ff <= issue_ff;
         done_ff   <= pp_vld_ff && pp_last_ff;
         if (start) begin
            issue_ff <= 1'b1;
         end else if (issue_ff && last_issue) begin
            issue_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff  <= PW'(a);
         b_ff  <= PW'(b);
         ia_ff <= '0;
         ib_ff <= '0;
      end else if (issue_ff) begin
         pp_ff      <= a_ff[ia_ff*LIMB_W +: LIMB_W] * b_ff[ib_ff*LIMB_W +: LIMB_W];
         sh_ff      <= SW'(ia_ff) + SW'(ib_ff);
         pp_last_ff <= last_issue;
         if (ib_ff == IW'(NL - 1)) begin
            ib_ff <= '0;
            ia_ff <= ia_ff + IW'(1);
         end else begin
            ib_ff <= ib_ff + IW'(1);
         end
      end
      if (start) begin
         acc_ff <= '0;
      end else if (pp_vld_ff) begin
         acc_ff <= acc_ff + pp_shifted;
      end
   end

endmodule

[sv/ncc_back.sv]
// Back end: turns one window's sums into the Q1.15 score with a shared multiplier,
// a restoring divider and a digit-by-digit square root. Depends on ncc_pkg, ncc_mul.
module ncc_back #(
   parameter int MAX_DIM = 1024,
   localparam int SUM_W = ncc_pkg::sum_width(MAX_DIM)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ncc_pkg::fifo_status_type       fifo_status,
   input  logic [SUM_W-1:0]               fifo_data,
   output logic                           fifo_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [ncc_pkg::SCORE_W-1:0] rsp_score,
   output logic                           rsp_degenerate
);
   import ncc_pkg::*;

   localparam int CNT_W = cnt_width(MAX_DIM);
   localparam int S1_W  = CNT_W + PIX_W;
   localparam int S2_W  = CNT_W + 2 * PIX_W;
   localparam int MW    = CNT_W + S2_W;
   localparam int NL    = (MW + LIMB_W - 1) / LIMB_W;
   localparam int PW    = NL * LIMB_W;
   localparam int DW    = 2 * MW + LIMB_W;
   localparam int SX_W  = 2 * ROOT_W;
   localparam int SR_W  = ROOT_W + 3;

   back_state_type state_ff, state_in;
   mul_step_type   step_ff;

   logic [CNT_W-1:0]   n_ff;
   logic [S1_W-1:0]    st_ff, si_ff;
   logic [S2_W-1:0]    stt_ff, sii_ff, sti_ff;
   logic [MW-1:0]      p0_ff, vt_ff, vi_ff, mag_ff;
   logic               neg_ff;
   logic [2*MW-1:0]    prod_ff;
   logic [DW-1:0]      rem_ff, div_ff;
   logic [QUO_W-1:0]   quo_ff, quo_in;
   logic [SX_W-1:0]    sx_ff;
   logic [SR_W-1:0]    sr_ff, sr_in, sq_r2, sq_trial;
   logic [ROOT_W-1:0]  root_ff, root_in, half_in;
   logic [5:0]         cnt_ff;
   logic [SCORE_W-1:0] score_ff, score_in;
   logic               deg_ff;

   logic              mul_start, mul_done;
   logic [MW-1:0]     mul_a, mul_b, r_lo, cov_mag;
   logic [2*PW-1:0]   mul_res;
   logic [MW:0]       cov_diff;
   logic              rem_ge, div_last, sqrt_last, var_zero;

   ncc_mul #(.AW(MW)) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a      (mul_a),
      .b      (mul_b),
      .done   (mul_done),
      .result (mul_res)
   );

   assign r_lo      = mul_res[MW-1:0];
   assign cov_diff  = {1'b0, p0_ff} - {1'b0, r_lo};
   assign cov_mag   = cov_diff[MW] ? (r_lo - p0_ff) : cov_diff[MW-1:0];
   assign var_zero  = (vt_ff == '0) || (vi_ff == '0);
   assign div_last  = (cnt_ff == 6'(QUO_W - 1));
   assign sqrt_last = (cnt_ff == 6'(ROOT_W - 1));
   assign rem_ge    = (rem_ff >= div_ff);
   assign quo_in    = {quo_ff[QUO_W-2:0], rem_ge};

   // one root digit per cycle
   assign sq_r2    = {sr_ff[SR_W-3:0], sx_ff[SX_W-1 -: 2]};
   assign sq_trial = SR_W'({root_ff, 2'b01});
   always_comb begin
      if (sq_r2 >= sq_trial) begin
         sr_in   = sq_r2 - sq_trial;
         root_in = {root_ff[ROOT_W-2:0], 1'b1};
      end else begin
         sr_in   = sq_r2;
         root_in = {root_ff[ROOT_W-2:0], 1'b0};
      end
   end

   // largest m with (2m-1)^2 not above the quotient
   assign half_in = ROOT_W'(({1'b0, root_in} + (ROOT_W+1)'(1)) >> 1);
   always_comb begin
      if (neg_ff) begin
         score_in = SCORE_W'(ROOT_W'(0) - half_in);
      end else if (half_in > ROOT_W'(SCORE_MAX)) begin
         score_in = SCORE_MAX;
      end else begin
         score_in = half_in[SCORE_W-1:0];
      end
   end

   always_comb begin
      unique case (step_ff)
         STEP_N_TT: begin mul_a = MW'(n_ff);  mul_b = MW'(stt_ff); end
         STEP_T_T:  begin mul_a = MW'(st_ff); mul_b = MW'(st_ff);  end
         STEP_N_II: begin mul_a = MW'(n_ff);  mul_b = MW'(sii_ff); end
         STEP_I_I:  begin mul_a = MW'(si_ff); mul_b = MW'(si_ff);  end
         STEP_N_TI: begin mul_a = MW'(n_ff);  mul_b = MW'(sti_ff); end
         STEP_T_I:  begin mul_a = MW'(st_ff); mul_b = MW'(si_ff);  end
         STEP_VAR:  begin mul_a = vt_ff;      mul_b = vi_ff;       end
         STEP_COV:  begin mul_a = mag_ff;     mul_b = mag_ff;      end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!fifo_status.empty) state_in = BK_MUL_ISSUE;
         end
         BK_MUL_ISSUE: state_in = BK_MUL_WAIT;
         BK_MUL_WAIT: begin
            if (mul_done) begin
               priority if (step_ff == STEP_T_I && var_zero) begin
                  state_in = BK_OUT;
               end else if (step_ff == STEP_COV) begin
                  state_in = BK_DIV;
               end else begin
                  state_in = BK_MUL_ISSUE;
               end
            end
         end
         BK_DIV: begin
            if (div_last) state_in = BK_SQRT;
         end
         BK_SQRT: begin
            if (sqrt_last) state_in = BK_OUT;
         end
         BK_OUT: begin
            if (rsp_ready) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      fifo_pop  = (state_ff == BK_IDLE) && !fifo_status.empty;
      mul_start = (state_ff == BK_MUL_ISSUE);
      rsp_valid = (state_ff == BK_OUT);
   end

   assign rsp_score      = score_ff;
   assign rsp_degenerate = deg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_N_TT;
         cnt_ff  <= '0;
      end else begin
         unique case (state_ff)
            BK_IDLE: begin
               step_ff <= STEP_N_TT;
               cnt_ff  <= '0;
            end
            BK_MUL_WAIT: begin
               if (mul_done) step_ff <= mul_step_type'(step_ff + 3'd1);
            end
            BK_DIV:  cnt_ff <= div_last ? 6'd0 : cnt_ff + 6'd1;
            BK_SQRT: cnt_ff <= cnt_ff + 6'd1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         BK_IDLE: begin
            if (!fifo_status.empty) begin
               {n_ff, st_ff, stt_ff, si_ff, sii_ff, sti_ff} <= fifo_data;
            end
         end
         BK_MUL_WAIT: begin
            if (mul_done) begin
               unique case (step_ff)
                  STEP_N_TT, STEP_N_II, STEP_N_TI: p0_ff <= r_lo;
                  STEP_T_T: vt_ff <= p0_ff - r_lo;
                  STEP_I_I: vi_ff <= p0_ff - r_lo;
                  STEP_T_I: begin
                     neg_ff   <= cov_diff[MW];
                     mag_ff   <= cov_mag;
                     score_ff <= '0;
                     deg_ff   <= var_zero;
                  end
                  STEP_VAR: prod_ff <= mul_res[2*MW-1:0];
                  STEP_COV: begin
                     // quotient of cov^2 * 2^32 by the variance product
                     rem_ff <= {mul_res[2*MW-1:0], {LIMB_W{1'b0}}};
                     div_ff <= {prod_ff, {LIMB_W{1'b0}}};
                     quo_ff <= '0;
                  end
               endcase
            end
         end
         BK_DIV: begin
            if (rem_ge) rem_ff <= rem_ff - div_ff;
            div_ff <= div_ff >> 1;
            quo_ff <= quo_in;
            if (div_last) begin
               sx_ff   <= SX_W'(quo_in);
               sr_ff   <= '0;
               root_ff <= '0;
            end
         end
         BK_SQRT: begin
            sx_ff   <= sx_ff << 2;
            sr_ff   <= sr_in;
            root_ff <= root_in;
            if (sqrt_last) score_ff <= score_in;
         end
         default: ;
      endcase
   end

endmodule

[sv/normalized_cross_correlation.sv]
// Normalized cross-correlation of a template window against an image window.
// Channels: req_* carries one template and one image pixel per transaction in raster
// order; rsp_* returns one score (signed Q1.15) and a degenerate flag per window;
// csr_* writes row_length (0), row_count (1) and sample_step (2), always ready.
// Throughput: the front end takes one pixel per cycle; req_ready drops only on the
// last pixel of a window while both entries of the two-deep sum queue are occupied.
// Result path: rsp_valid rises once the back end has formed 8 products on a shared
// multiplier built from 32x32 partial products and run a 33-step divider and a 17-step
// root; a flat window skips the last two products, the divider and the root. The back
// end takes one window at a time, so short windows fill the queue and stall req_ready.
// A stalled rsp_ready holds the score in its output register; the front end keeps
// accumulating and stalls only when the queue is full at a window end.
// Reset (synchronous, active high) restores the register defaults 16, 16 and 1,
// clears the window position and sums, and empties the queue.
// Depends on ncc_pkg, ncc_front, ncc_fifo, ncc_back and the assertion macro header.
`include "normalized_cross_correlation_defines.svh"
module normalized_cross_correlation #(
   parameter int MAX_DIM = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ncc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ncc_pkg::CFG_W-1:0]          csr_data,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [ncc_pkg::PIX_W-1:0]          req_template_pixel,
   input  logic [ncc_pkg::PIX_W-1:0]          req_image_pixel,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [ncc_pkg::SCORE_W-1:0] rsp_score,
   output logic                               rsp_degenerate
);
   import ncc_pkg::*;

   localparam int SUM_W = sum_width(MAX_DIM);

   fifo_status_type  fifo_status;
   logic             fifo_push, fifo_pop;
   logic [SUM_W-1:0] fifo_wdata, fifo_rdata;

   ncc_front #(.MAX_DIM(MAX_DIM)) u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_template_pixel (req_template_pixel),
      .req_image_pixel    (req_image_pixel),
      .fifo_status        (fifo_status),
      .push               (fifo_push),
      .push_data          (fifo_wdata)
   );

   ncc_fifo #(.W(SUM_W)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data (fifo_wdata),
      .pop       (fifo_pop),
      .pop_data  (fifo_rdata),
      .status    (fifo_status)
   );

   ncc_back #(.MAX_DIM(MAX_DIM)) u_back (
      .clock          (clock),
      .reset          (reset),
      .fifo_status    (fifo_status),
      .fifo_data      (fifo_rdata),
      .fifo_pop       (fifo_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_score      (rsp_score),
      .rsp_degenerate (rsp_degenerate)
   );

   `NCC_ASSERT_IMP(a_push_not_full, fifo_push, !fifo_status.full, "push into full queue")
   `NCC_ASSERT_IMP(a_pop_not_empty, fifo_pop, !fifo_status.empty, "pop from empty queue")
   `NCC_ASSERT_IMP(a_degenerate_zero, rsp_valid && rsp_degenerate, rsp_score == '0, "flat score")
   `NCC_ASSERT_NXT(a_single_result, rsp_valid && rsp_ready, !rsp_valid, "result repeated")

endmodule
